@@ rtl/double_hash_key_set_top_defines.svh @@
// ---------------------------------------------------------------------------
// double_hash_key_set_top_defines
// Assertion macros for the key set block; empty bodies under synthesis.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_HASH_KEY_SET_TOP_DEFINES_SVH
`define DOUBLE_HASH_KEY_SET_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// expression must hold at every edge outside reset
`define DHKS_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// pre at one edge implies post at the next edge
`define DHKS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define DHKS_ASSERT(name, expr, msg)
`define DHKS_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

@@ rtl/dhks_pkg.sv @@
// ---------------------------------------------------------------------------
// dhks_pkg
// Shared widths, status codes and the queue entry type of the key set.
// ---------------------------------------------------------------------------
package dhks_pkg;

  localparam int KEY_W           = 28;
  localparam int FIELD_LETTERS   = 12;
  localparam int LETTERS_W       = 2 * FIELD_LETTERS;
  localparam int LENGTH_W        = 4;
  localparam int STATUS_W        = 2;
  localparam int DEF_TABLE_SIZE  = 1021;
  localparam int DEF_MAX_LETTERS = 12;
  localparam int QUEUE_DEPTH     = 4;

  // request selector
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // classified request handed from front to back
  typedef struct packed {
    logic             insert;
    logic             zero;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

@@ rtl/dhks_req_if.sv @@
// ---------------------------------------------------------------------------
// dhks_req_if
// Request channel: insert/find selector and a short letter string.
// ---------------------------------------------------------------------------
interface dhks_req_if;
  import dhks_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [LETTERS_W-1:0] letters;
  logic [LENGTH_W-1:0]  length;

  modport source (output valid, req_type, letters, length, input ready);
  modport sink   (input valid, req_type, letters, length, output ready);
endinterface

@@ rtl/dhks_resp_if.sv @@
// ---------------------------------------------------------------------------
// dhks_resp_if
// Response channel: one status code per request.
// ---------------------------------------------------------------------------
interface dhks_resp_if;
  import dhks_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

@@ rtl/dhks_front.sv @@
// ---------------------------------------------------------------------------
// dhks_front
// Key build and probe start/step computation, five pipeline stages.
// ---------------------------------------------------------------------------
module dhks_front #(
  parameter int TABLE_SIZE  = dhks_pkg::DEF_TABLE_SIZE,
  parameter int MAX_LETTERS = dhks_pkg::DEF_MAX_LETTERS,
  parameter int IDX_W       = $clog2(TABLE_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  dhks_req_if.sink         req,
  input  logic             hold,
  output logic             out_valid,
  input  logic             out_ready,
  output dhks_pkg::entry_t out_entry,
  output logic [IDX_W-1:0] out_pos,
  output logic [IDX_W-1:0] out_step
);
  import dhks_pkg::*;

  localparam int NCAP   = (MAX_LETTERS < FIELD_LETTERS) ? MAX_LETTERS : FIELD_LETTERS;
  localparam int GROUPS = FIELD_LETTERS / 4;

  // mod divisors and floor(2^KEY_W / d) reciprocals
  localparam logic [KEY_W-1:0] D1 = KEY_W'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] D2 = KEY_W'(TABLE_SIZE - 1);
  localparam logic [KEY_W-1:0] M1 = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);
  localparam logic [KEY_W-1:0] M2 = KEY_W'((64'd1 << KEY_W) / (TABLE_SIZE - 1));

  function automatic logic [KEY_W-1:0] pow5(input int e);
    logic [63:0] acc;
    acc = 64'd1;
    for (int k = 0; k < e; k++) acc = acc * 64'd5;
    return KEY_W'(acc);
  endfunction

  logic                advance;
  logic [LENGTH_W-1:0] n_used;
  logic [KEY_W-1:0]    term [FIELD_LETTERS];
  logic [KEY_W-1:0]    grp  [GROUPS];

  logic             s1_valid, s2_valid, s3_valid, s4_valid;
  logic             s1_insert, s2_insert, s3_insert, s4_insert;
  logic [KEY_W-1:0] s1_g [GROUPS];
  logic [KEY_W-1:0] s2_key, s3_key, s4_key;
  logic [KEY_W-1:0] s3_q1, s3_q2, s4_qd1, s4_qd2;
  logic             s3_zero, s4_zero;

  logic [KEY_W-1:0]   key_sum;
  logic [2*KEY_W-1:0] prod1, prod2, prodd1, prodd2;
  logic [KEY_W-1:0]   r1, r2, rem1, rem2;

  assign advance   = !out_valid || out_ready;
  assign req.ready = advance && !hold;

  always_comb begin
    n_used = (req.length > LENGTH_W'(NCAP)) ? LENGTH_W'(NCAP) : req.length;
    for (int i = 0; i < FIELD_LETTERS; i++) begin
      term[i] = (LENGTH_W'(i) < n_used)
              ? KEY_W'(pow5(i) * KEY_W'({1'b0, req.letters[2*i +: 2]} + 3'd1))
              : '0;
    end
    for (int j = 0; j < GROUPS; j++) begin
      grp[j] = term[4*j] + term[4*j+1] + term[4*j+2] + term[4*j+3];
    end
  end

  always_comb begin
    key_sum = '0;
    for (int j = 0; j < GROUPS; j++) key_sum = key_sum + s1_g[j];
  end

  assign prod1  = s2_key * M1;
  assign prod2  = s2_key * M2;
  assign prodd1 = s3_q1 * D1;
  assign prodd2 = s3_q2 * D2;

  // estimate is at most one low: one correction step
  assign r1   = s4_key - s4_qd1;
  assign r2   = s4_key - s4_qd2;
  assign rem1 = (r1 >= D1) ? (r1 - D1) : r1;
  assign rem2 = (r2 >= D2) ? (r2 - D2) : r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= req.valid && req.ready;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_insert <= (req.req_type == REQ_INSERT);
      s1_g      <= grp;
      s2_insert <= s1_insert;
      s2_key    <= key_sum;
      s3_insert <= s2_insert;
      s3_key    <= s2_key;
      s3_zero   <= (s2_key == '0);
      s3_q1     <= prod1[2*KEY_W-1:KEY_W];
      s3_q2     <= prod2[2*KEY_W-1:KEY_W];
      s4_insert <= s3_insert;
      s4_key    <= s3_key;
      s4_zero   <= s3_zero;
      s4_qd1    <= prodd1[KEY_W-1:0];
      s4_qd2    <= prodd2[KEY_W-1:0];
      out_entry.insert <= s4_insert;
      out_entry.zero   <= s4_zero;
      out_entry.key    <= s4_key;
      out_pos          <= rem1[IDX_W-1:0];
      out_step         <= IDX_W'(rem2 + KEY_W'(1));
    end
  end

endmodule

@@ rtl/dhks_queue.sv @@
// ---------------------------------------------------------------------------
// dhks_queue
// Small register queue between front and back.
// ---------------------------------------------------------------------------
module dhks_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = dhks_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

@@ rtl/dhks_back.sv @@
// ---------------------------------------------------------------------------
// dhks_back
// Slot table, clearing pass and the probe walk; one probe per cycle.
// ---------------------------------------------------------------------------
`include "double_hash_key_set_top_defines.svh"

module dhks_back #(
  parameter int TABLE_SIZE = dhks_pkg::DEF_TABLE_SIZE,
  parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  dhks_pkg::entry_t q_entry,
  input  logic [IDX_W-1:0] q_pos,
  input  logic [IDX_W-1:0] q_step,
  dhks_resp_if.source      resp,
  output logic             clearing
);
  import dhks_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE} state_t;

  localparam logic [IDX_W:0]   TS   = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

  state_t              state;
  logic [IDX_W-1:0]    clr_addr;
  logic [KEY_W-1:0]    key_q;
  logic                insert_q;
  logic [IDX_W-1:0]    pos, step, probes;
  logic                resp_valid;
  logic [STATUS_W-1:0] resp_status;

  logic [KEY_W-1:0] slot_keys [TABLE_SIZE];
  logic [KEY_W-1:0] rdata;

  logic             out_free, hit, empty, last, done, finish, pop;
  logic             resp_load;
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] nxt_pos;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data;

  assign resp.valid  = resp_valid;
  assign resp.status = resp_status;
  assign clearing    = (state == S_CLEAR);

  assign out_free = !resp_valid || resp.ready;
  assign hit      = (rdata == key_q);
  assign empty    = (rdata == '0);
  assign last     = (probes == LAST);
  assign done     = (state == S_PROBE) && (hit || empty || last);
  assign finish   = done && out_free;

  assign sum     = {1'b0, pos} + {1'b0, step};
  assign nxt_pos = (sum >= TS) ? IDX_W'(sum - TS) : sum[IDX_W-1:0];

  assign q_ready = (state == S_IDLE) && out_free;
  assign pop     = q_valid && q_ready;

  // a new response is loaded for an empty string or at the end of a walk
  assign resp_load = (pop && q_entry.zero) || finish;

  assign rd_en   = (pop && !q_entry.zero) || ((state == S_PROBE) && !done);
  assign rd_addr = (state == S_IDLE) ? q_pos : nxt_pos;

  assign wr_en   = clearing || (finish && !hit && empty && insert_q);
  assign wr_addr = clearing ? clr_addr : pos;
  assign wr_data = clearing ? '0 : key_q;

  always_ff @(posedge clk) begin
    if (wr_en) slot_keys[wr_addr] <= wr_data;
    if (rd_en) rdata <= slot_keys[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      resp_valid <= 1'b0;
    end else begin
      if (resp_load) resp_valid <= 1'b1;
      else if (resp_valid && resp.ready) resp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            key_q    <= q_entry.key;
            insert_q <= q_entry.insert;
            pos      <= q_pos;
            step     <= q_step;
            probes   <= '0;
            if (q_entry.zero) begin
              // empty string never stored
              resp_status <= ST_ABSENT;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (!done) begin
            pos    <= nxt_pos;
            probes <= probes + IDX_W'(1);
          end else if (out_free) begin
            resp_status <= hit ? ST_PRESENT : (empty ? ST_ABSENT : ST_FULL);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DHKS_ASSERT(a_no_pop_clear, !(clearing && q_ready), "queue popped during clear")
  `DHKS_ASSERT(a_pos_range, (state != S_PROBE) || ({1'b0, pos} < TS), "probe index out of range")
  `DHKS_ASSERT(a_write_key, !(wr_en && !clearing) || (insert_q && empty && wr_data == key_q), "bad store")
  `DHKS_ASSERT_NEXT(a_probe_step, (state == S_PROBE) && !done, (state == S_PROBE) && (probes == IDX_W'($past(probes) + 1)), "probe count skipped")

endmodule

@@ rtl/double_hash_key_set_top.sv @@
// ---------------------------------------------------------------------------
// double_hash_key_set_top
// Set of short nucleotide strings in a double-hashed open-address table.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                          | accepted when
//  --------+-----+----------------------------------+-----------------------
//  req     | in  | req_type, letters[23:0], length  | req.valid & req.ready
//  resp    | out | status[1:0]                      | resp.valid & resp.ready
//
//  Front: five-stage pipeline builds the base-5 key and the probe start
//  (key mod TABLE_SIZE) and step (1 + key mod (TABLE_SIZE-1)) with
//  reciprocal multiplies; unless stalled it takes one request a cycle
//  into a 4-entry queue. Back: one table read port, one read per probe
//  (none for an empty string); back probing sets the sustained rate.
//  After reset the back clears the table one slot a cycle, all TABLE_SIZE
//  slots, and req.ready stays low meanwhile.
//  Stalls: a pending response holds the back; a full queue stalls the front.
//
module double_hash_key_set_top #(
  parameter int TABLE_SIZE  = dhks_pkg::DEF_TABLE_SIZE,
  parameter int MAX_LETTERS = dhks_pkg::DEF_MAX_LETTERS
) (
  input  logic        clk,
  input  logic        rst,
  dhks_req_if.sink    req,
  dhks_resp_if.source resp
);
  import dhks_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int QW    = $bits(entry_t) + 2 * IDX_W;

  logic             clearing;

  // front -> queue
  logic             f_valid, f_ready;
  entry_t           f_entry;
  logic [IDX_W-1:0] f_pos, f_step;

  // queue -> back
  logic             b_valid, b_ready;
  logic [QW-1:0]    b_data;
  entry_t           b_entry;
  logic [IDX_W-1:0] b_pos, b_step;

  assign {b_entry, b_pos, b_step} = b_data;

  dhks_front #(
    .TABLE_SIZE  (TABLE_SIZE),
    .MAX_LETTERS (MAX_LETTERS),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .hold      (clearing),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_entry (f_entry),
    .out_pos   (f_pos),
    .out_step  (f_step)
  );

  dhks_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_entry, f_pos, f_step}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  dhks_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_entry  (b_entry),
    .q_pos    (b_pos),
    .q_step   (b_step),
    .resp     (resp),
    .clearing (clearing)
  );

endmodule
